/* rtl/htlp_pkg.sv */
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared constants, codes and controller/datapath types for the linear-probe
// hash table.
// ----------------------------------------------------------------------------
package htlp_pkg;

  // Slot count. It must be a power of two, because the home slot is taken
  // from the low key bits.
  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int HALF_SIZE  = TABLE_SIZE / 2;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = KEY_W + VAL_W;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_WIPE,
    ST_RESP
  } htlp_state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_HIT,
    RES_REFUSE
  } htlp_res_t;

  typedef struct packed {
    logic      load;      // capture the incoming item, start its probe
    logic      advance;   // step to the next slot
    logic      write;     // store key and value at the current slot
    logic      wipe;      // zero the current slot and step on
    logic      res_load;  // latch a result
    htlp_res_t res_sel;
    logic      out_load;  // move the result into the output register
  } htlp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            empty;
    logic            match;
    logic            exhausted;
    logic            full;
    logic            val_zero;
    logic            last_slot;
    logic            out_busy;
  } htlp_sts_t;

endpackage

/* rtl/htlp_if.sv */
// ----------------------------------------------------------------------------
// htlp_if
// Valid/ready channels for requests into and results out of the hash table.
// ----------------------------------------------------------------------------
interface htlp_in_if import htlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface htlp_out_if import htlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] stored_value;
  logic             refused;

  modport source (output valid, output hit, output stored_value, output refused, input ready);
  modport sink   (input valid, input hit, input stored_value, input refused, output ready);
endinterface

/* rtl/htlp_ram.sv */
// ----------------------------------------------------------------------------
// htlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htlp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/htlp_ctrl.sv */
// ----------------------------------------------------------------------------
// htlp_ctrl
// Sequencer for the hash table: clearing sweeps, probe loop, insert write and
// result hand-off.
// ----------------------------------------------------------------------------
module htlp_ctrl import htlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  htlp_sts_t sts,
  output htlp_cmd_t cmd
);

  htlp_state_t state_r, state_nxt;
  logic        accept;
  logic        is_insert;
  logic        fin;
  logic        do_write;
  htlp_res_t   sel;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_insert = (sts.op == OP_INSERT);

  // Probe decision for the slot whose data is on the RAM output.
  always_comb begin
    fin      = 1'b0;
    do_write = 1'b0;
    sel      = RES_ZERO;
    if (sts.match) begin
      fin = 1'b1;
      sel = RES_HIT;
    end else if (sts.empty) begin
      fin = 1'b1;
      if (is_insert) begin
        if (sts.full) begin
          sel = RES_REFUSE;
        end else if (!sts.val_zero) begin
          do_write = 1'b1;
        end
      end
    end else if (sts.exhausted) begin
      fin = 1'b1;
      sel = is_insert ? RES_REFUSE : RES_ZERO;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.last_slot) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (sts.in_op == OP_CLEAR) begin
            state_nxt = ST_WIPE;
          end else if (sts.in_op inside {OP_LOOKUP, OP_INSERT}) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_CHECK: begin
        if (fin) state_nxt = do_write ? ST_WRITE : ST_RESP;
      end
      ST_WRITE: state_nxt = ST_RESP;
      ST_WIPE: begin
        if (sts.last_slot) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, advance: 1'b0, write: 1'b0, wipe: 1'b0,
            res_load: 1'b0, res_sel: RES_ZERO, out_load: 1'b0};
    case (state_r)
      ST_INIT, ST_WIPE: cmd.wipe = 1'b1;
      ST_IDLE: begin
        cmd.load     = accept;
        cmd.res_load = accept;
      end
      ST_CHECK: begin
        cmd.advance  = !fin;
        cmd.res_load = fin;
        cmd.res_sel  = sel;
      end
      ST_WRITE: cmd.write = 1'b1;
      ST_RESP:  cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/htlp_dp.sv */
// ----------------------------------------------------------------------------
// htlp_dp
// Datapath: slot RAM, probe address and count, entry count, result and
// output registers.
// ----------------------------------------------------------------------------
module htlp_dp import htlp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  htlp_cmd_t         cmd,
  output htlp_sts_t         sts,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_hit,
  output logic [VAL_W-1:0]  out_stored_value,
  output logic              out_refused
);

  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] probe_cnt_r;
  logic [CNT_W-1:0]  entry_cnt_r;
  logic              res_hit_r;
  logic [VAL_W-1:0]  res_val_r;
  logic              res_refused_r;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_refused_r;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_data;
  logic [SLOT_W-1:0] rd_data;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  // Home slot is the key modulo the table size; a clear sweeps from slot 0.
  assign load_addr = (in_operation == OP_CLEAR) ? '0 : in_key[ADDR_W-1:0];

  // Read address runs one step ahead so the RAM output matches addr_r.
  always_comb begin
    addr_nxt = addr_r;
    if (cmd.load) begin
      addr_nxt = load_addr;
    end else if (cmd.advance || cmd.wipe) begin
      addr_nxt = addr_r + 1'b1;
    end
  end

  assign wr_en   = cmd.write || cmd.wipe;
  assign wr_data = cmd.write ? {key_r, val_r} : '0;

  htlp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (addr_r),
    .wr_data   (wr_data),
    .rd_addr   (addr_nxt),
    .rd_data_r (rd_data)
  );

  assign rd_key = rd_data[SLOT_W-1:VAL_W];
  assign rd_val = rd_data[VAL_W-1:0];

  assign sts.in_op     = in_operation;
  assign sts.op        = op_r;
  assign sts.empty     = (rd_val == '0);
  assign sts.match     = (rd_val != '0) && (rd_key == key_r);
  assign sts.exhausted = (probe_cnt_r == ADDR_W'(TABLE_SIZE - 1));
  assign sts.full      = (entry_cnt_r >= CNT_W'(HALF_SIZE));
  assign sts.val_zero  = (val_r == '0);
  assign sts.last_slot = (addr_r == ADDR_W'(TABLE_SIZE - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      probe_cnt_r <= '0;
      entry_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      if (cmd.load) begin
        probe_cnt_r <= '0;
      end else if (cmd.advance) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
      if (cmd.wipe) begin
        entry_cnt_r <= '0;
      end else if (cmd.write) begin
        entry_cnt_r <= entry_cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.res_load) begin
      res_hit_r     <= (cmd.res_sel == RES_HIT);
      res_val_r     <= (cmd.res_sel == RES_HIT) ? rd_val : '0;
      res_refused_r <= (cmd.res_sel == RES_REFUSE);
    end
    if (cmd.out_load) begin
      out_hit_r     <= res_hit_r;
      out_val_r     <= res_val_r;
      out_refused_r <= res_refused_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_stored_value = out_val_r;
  assign out_refused      = out_refused_r;

endmodule

/* rtl/hash_table_linear_probe_top.sv */
// ----------------------------------------------------------------------------
// hash_table_linear_probe_top
// Open-addressing hash table of 1024 key/value slots with linear probing.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (operation, key, value); each gives exactly one
// beat on out_ch (hit, stored_value, refused), in request order.
// Operations: lookup, insert (refused once 512 entries are held), clear.
// Requests are worked through by the probe loop, one slot read per cycle from
// a single-port-read slot RAM with registered output:
//   lookup: probes on from the home slot until a match, an empty slot or
//           every slot has been probed, then hands the result off;
//   insert that writes: adds a write step before the hand-off;
//   clear: a sweep over the whole slot RAM, then the hand-off;
//   unused operation code: no probe, all-zero result.
// One item is worked on at a time; in_ch.ready is high only between items.
// After reset the block sweeps the whole slot RAM to zero with
// in_ch.ready low, then accepts requests.
// out_ch is a registered output: a finished result waits there while the
// receiver stalls and the next request is still accepted and probed; the
// block holds before handing off a further result until that beat is taken.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_top import htlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  htlp_in_if.sink     in_ch,
  htlp_out_if.source  out_ch
);

  htlp_cmd_t cmd;
  htlp_sts_t sts;

  htlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  htlp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_ch.operation),
    .in_key           (in_ch.key),
    .in_value         (in_ch.value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_hit          (out_ch.hit),
    .out_stored_value (out_ch.stored_value),
    .out_refused      (out_ch.refused)
  );

endmodule

/* test/hash_table_linear_probe_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_linear_probe_top_tb
// Drives lookups, inserts and clears into the linear-probe hash table and
// checks every result beat against a slot-level shadow of the table. Covers
// probe wrap at the last slot, colliding keys, half-capacity refusal, inserts
// with zero values and the unused operation code, with random idling on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_top_tb;
  import htlp_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] stored_value;
    logic             refused;
  } table_answer_t;

  typedef enum {PROBE_EMPTY, PROBE_MATCH, PROBE_EXHAUSTED} probe_result_t;

  class table_scoreboard;
    logic [KEY_W-1:0] slot_key [TABLE_SIZE];
    logic [VAL_W-1:0] slot_val [TABLE_SIZE];
    int unsigned      entries;
    table_answer_t    awaited[$];
    int unsigned      mismatches, answers, hits, refusals, stored_new, wipes;

    function new();
      wipe_table();
    endfunction

    function void wipe_table();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      entries = 0;
    endfunction

    function probe_result_t locate(input logic [KEY_W-1:0] key,
                                   output logic [ADDR_W-1:0] pos);
      logic [ADDR_W-1:0] p;
      p = key[ADDR_W-1:0];
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (slot_val[p] == '0) begin
          pos = p;
          return PROBE_EMPTY;
        end
        if (slot_key[p] == key) begin
          pos = p;
          return PROBE_MATCH;
        end
        p = p + 1'b1;
      end
      pos = '0;
      return PROBE_EXHAUSTED;
    endfunction

    function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      table_answer_t     ans;
      logic [ADDR_W-1:0] pos;
      probe_result_t     pr;
      ans = '0;
      case (op)
        OP_LOOKUP: begin
          pr = locate(key, pos);
          if (pr == PROBE_MATCH) begin
            ans.hit = 1'b1;
            ans.stored_value = slot_val[pos];
          end
        end
        OP_INSERT: begin
          pr = locate(key, pos);
          if (pr == PROBE_MATCH) begin
            ans.hit = 1'b1;
            ans.stored_value = slot_val[pos];
          end else if (entries >= HALF_SIZE || pr == PROBE_EXHAUSTED) begin
            ans.refused = 1'b1;
          end else if (value != '0) begin
            slot_key[pos] = key;
            slot_val[pos] = value;
            entries++;
            stored_new++;
          end
        end
        OP_CLEAR: begin
          wipe_table();
          wipes++;
        end
        default: ;
      endcase
      awaited.push_back(ans);
    endfunction

    function void check_result(input logic hit, input logic [VAL_W-1:0] stored_value,
                               input logic refused);
      table_answer_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("[%0t] result beat with nothing expected: hit=%0b value=%h refused=%0b",
                 $time, hit, stored_value, refused);
        return;
      end
      exp = awaited.pop_front();
      answers++;
      if (exp.hit) hits++;
      if (exp.refused) refusals++;
      if (hit !== exp.hit) begin
        mismatches++;
        $display("[%0t] hit mismatch: expected %0b, actual %0b", $time, exp.hit, hit);
      end
      if (stored_value !== exp.stored_value) begin
        mismatches++;
        $display("[%0t] stored_value mismatch: expected %h, actual %h",
                 $time, exp.stored_value, stored_value);
      end
      if (refused !== exp.refused) begin
        mismatches++;
        $display("[%0t] refused mismatch: expected %0b, actual %0b",
                 $time, exp.refused, refused);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   idle_pct = 25;
  int   stall_pct = 25;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [KEY_W-1:0] stored_keys[$];

  table_scoreboard sb = new();

  htlp_in_if  in_ch();
  htlp_out_if out_ch();

  hash_table_linear_probe_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL hash_table_linear_probe_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.operation, in_ch.key, in_ch.value);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.hit, out_ch.stored_value, out_ch.refused);
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  // Result side: stall in bursts, with stretches of steady ready.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if ($urandom_range(0, 15) == 0) stall_pct = pick_pct();
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.key   <= $urandom();
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= key;
    in_ch.value     <= value;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (items_sent % 64 == 0) idle_pct = pick_pct();
  endtask

  // Random upper bits, home slot drawn from a window so keys collide.
  function automatic logic [KEY_W-1:0] key_near(input int unsigned base,
                                                input int unsigned spread);
    logic [KEY_W-1:0] k;
    k = $urandom();
    k[ADDR_W-1:0] = ADDR_W'((base + $urandom_range(0, spread)) % TABLE_SIZE);
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    v = $urandom();
    if ($urandom_range(0, 99) < 3) v = '0;
    else if (v == '0) v = 1;
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] pick_stored();
    if (stored_keys.size() == 0) return $urandom();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic insert_fresh(input int unsigned base, input int unsigned spread);
    logic [KEY_W-1:0] k;
    k = $urandom_range(0, 1) ? key_near(base, spread) : $urandom();
    stored_keys.push_back(k);
    send_item(OP_INSERT, k, random_value());
  endtask

  task automatic clear_table();
    stored_keys.delete();
    send_item(OP_CLEAR, $urandom(), $urandom());
  endtask

  task automatic random_mix(input int n, input int unsigned base, input int unsigned spread,
                            input int ins_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        if ($urandom_range(0, 3) == 0) send_item(OP_INSERT, pick_stored(), random_value());
        else insert_fresh(base, spread);
      end else if (r < 97) begin
        send_item(OP_LOOKUP, ($urandom_range(0, 2) != 0) ? pick_stored()
                                                        : key_near(base, spread), $urandom());
      end else begin
        send_item(OP_NOP, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOOKUP;
    in_ch.key       <= '0;
    in_ch.value     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, wrap past the last slot, zero value, no-op.
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0005);
    send_item(OP_INSERT, 32'h0000_0400, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0400, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_07FF, 32'h8000_0000);
    send_item(OP_LOOKUP, 32'h0000_07FF, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_03FF, 32'h1234_5678);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_NOP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'hFFFF_FBFF, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_03FF, 32'h0000_0000);
    send_item(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h5555_5555, 32'h0000_0000);
    send_item(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Fill to half capacity with a cluster that wraps past the last slot.
    clear_table();
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_LOOKUP, pick_stored(), $urandom());
      else insert_fresh(990, 60);
    end
    // At half capacity: new keys refused, present keys still hit.
    random_mix(40, 990, 60, 70);

    // Moderate load, tight collision window at a random spot.
    clear_table();
    random_mix(500, $urandom_range(0, TABLE_SIZE - 1), 15, 55);

    // Last stretch without idling on either side.
    calm = 1'b1;
    clear_table();
    random_mix(200, 0, TABLE_SIZE - 1, 50);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d requests: %0d hits, %0d refusals.",
             sb.answers, items_sent, sb.hits, sb.refusals);
    $display("New keys stored: %0d, table clears: %0d, mismatches: %0d.",
             sb.stored_new, sb.wipes, sb.mismatches);
    if (sb.mismatches == 0)
      $display("PASS hash_table_linear_probe_top");
    else
      $display("FAIL hash_table_linear_probe_top");
    $finish;
  end

endmodule

/* files.f */
rtl/htlp_pkg.sv
rtl/htlp_if.sv
rtl/htlp_ram.sv
rtl/htlp_ctrl.sv
rtl/htlp_dp.sv
rtl/hash_table_linear_probe_top.sv
test/hash_table_linear_probe_top_tb.sv
